// ===== src/trht_pkg.sv =====
// Shared types, codes and helpers for the topmost rectangle hit test.
`default_nettype none
package trht_pkg;

	localparam int IDX_W     = 4;
	localparam int PCT_W     = 7;
	localparam int LEVEL_W   = 9;
	localparam int CHAR_W    = 8;
	localparam int PT_W      = 8;
	localparam int COUNT_W   = 5;
	localparam int CMP_W     = 9;

	localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'd32;

	// pct*256/100 == pct*64/25 ~= (pct * 64 * ceil(2^17/25)) >> 17, exact for pct < 128
	localparam int SCALE_SHIFT = 17;
	localparam int PROD_W      = 26;
	localparam logic [PROD_W-1:0] PCT_RECIP = 26'd335552;

	typedef enum logic {
		CMD_LOAD  = 1'b0,
		CMD_QUERY = 1'b1
	} cmd_t;

	// transaction moving down the cell row
	typedef struct packed {
		logic              vld;
		cmd_t              cmd;
		logic [IDX_W-1:0]  idx;
		logic [PCT_W-1:0]  red;
		logic [PCT_W-1:0]  green;
		logic [PCT_W-1:0]  blue;
		logic [CHAR_W-1:0] label;
	} op_t;

	// running query result
	typedef struct packed {
		logic              hit;
		logic [IDX_W-1:0]  hit_index;
		logic [PCT_W-1:0]  red;
		logic [PCT_W-1:0]  green;
		logic [PCT_W-1:0]  blue;
		logic [CHAR_W-1:0] glyph;
	} res_t;

	function automatic logic [LEVEL_W-1:0] scale_pct(input logic [PCT_W-1:0] pct);
		logic [PROD_W-1:0] prod;
		prod = PROD_W'(pct) * PCT_RECIP;
		return prod[SCALE_SHIFT +: LEVEL_W];
	endfunction

endpackage
`default_nettype wire

// ===== src/trht_cell.sv =====
// One table entry plus its stage of the query/load row.
`default_nettype none
module trht_cell import trht_pkg::*; #(
	parameter int INDEX      = 0,
	parameter int COORD_BITS = 8
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       advance,
	input  wire logic [COUNT_W-1:0]         count,
	input  wire op_t                        in_op,
	input  wire logic [3:0][COORD_BITS-1:0] in_crd,
	input  wire res_t                       in_res,
	output op_t                             out_op,
	output logic [3:0][COORD_BITS-1:0]      out_crd,
	output res_t                            out_res
);

	localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(INDEX);

	logic [COORD_BITS-1:0] left_q, bottom_q, right_q, top_q;
	logic [PCT_W-1:0]      red_q, green_q, blue_q;
	logic [CHAR_W-1:0]     label_q;

	logic                  op_vld_s1;
	op_t                   op_s1;
	logic [3:0][COORD_BITS-1:0] crd_s1;
	res_t                  res_s1;

	logic                  do_load;
	logic                  match;
	res_t                  res_nxt;

	always_comb begin
		do_load = in_op.vld && (in_op.cmd == CMD_LOAD) && (CMP_W'(in_op.idx) == MY_IDX);
		match   = (in_op.cmd == CMD_QUERY) && (CMP_W'(count) > MY_IDX) &&
		          (in_crd[0] >= left_q) && (in_crd[1] >= bottom_q) &&
		          (in_crd[0] <= right_q) && (in_crd[1] <= top_q);
		res_nxt = in_res;
		if (match) begin
			res_nxt.hit       = 1'b1;
			res_nxt.hit_index = IDX_W'(INDEX);
			res_nxt.red       = red_q;
			res_nxt.green     = green_q;
			res_nxt.blue      = blue_q;
			res_nxt.glyph     = label_q;
		end
	end

	// entry storage, undefined until loaded
	always_ff @(posedge clk) begin
		if (advance && do_load) begin
			left_q   <= in_crd[0];
			bottom_q <= in_crd[1];
			right_q  <= in_crd[2];
			top_q    <= in_crd[3];
			red_q    <= in_op.red;
			green_q  <= in_op.green;
			blue_q   <= in_op.blue;
			label_q  <= in_op.label;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_vld_s1 <= 1'b0;
		end else if (advance) begin
			op_vld_s1 <= in_op.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			op_s1  <= in_op;
			crd_s1 <= in_crd;
			res_s1 <= res_nxt;
		end
	end

	always_comb begin
		out_op     = op_s1;
		out_op.vld = op_vld_s1;
		out_crd    = crd_s1;
		out_res    = res_s1;
	end

endmodule
`default_nettype wire

// ===== src/topmost_rectangle_hit_test.sv =====
// Topmost rectangle hit test: a row of entry cells searched by passing queries.
//
// Request channel (req_valid/req_stall): one transaction per load or query.
// A load (command 0) writes slot entry_index; it gives no result. A query
// (command 1) gives point_x/point_y and yields exactly one result on the
// response channel (rsp_valid/rsp_stall) with the topmost hit among entries
// 0 .. entry_count-1, or hit=0, zero levels and a space glyph on a miss.
// The configuration channel (cfg_valid/cfg_ready) writes entry_count; it is
// always ready. The user must write it only while no transaction is in
// flight; the block does not enforce this. Every transaction walks the row
// of ENTRIES cells, one cell per cycle while the row is not frozen, so
// loads and queries keep their order; one transaction is accepted per cycle
// while req_stall is low. While the receiver stalls with a result held, the
// whole row freezes and req_stall is high. Reset clears entry_count and all
// valid flags; the table contents stay undefined until loaded.
`default_nettype none
module topmost_rectangle_hit_test import trht_pkg::*; #(
	parameter int ENTRIES    = 16,
	parameter int COORD_BITS = 8
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [COUNT_W-1:0] entry_count,
	input  wire logic               req_valid,
	output logic                    req_stall,
	input  wire logic               command,
	input  wire logic [IDX_W-1:0]   entry_index,
	input  wire logic [PT_W-1:0]    left,
	input  wire logic [PT_W-1:0]    bottom,
	input  wire logic [PT_W-1:0]    right,
	input  wire logic [PT_W-1:0]    top,
	input  wire logic [PCT_W-1:0]   red,
	input  wire logic [PCT_W-1:0]   green,
	input  wire logic [PCT_W-1:0]   blue,
	input  wire logic [CHAR_W-1:0]  label_char,
	input  wire logic [PT_W-1:0]    point_x,
	input  wire logic [PT_W-1:0]    point_y,
	output logic                    rsp_valid,
	input  wire logic               rsp_stall,
	output logic                    hit,
	output logic [IDX_W-1:0]        hit_index,
	output logic [LEVEL_W-1:0]      red_level,
	output logic [LEVEL_W-1:0]      green_level,
	output logic [LEVEL_W-1:0]      blue_level,
	output logic [CHAR_W-1:0]       glyph
);

	logic [COUNT_W-1:0] count_q;
	logic               rsp_valid_q;
	logic               hit_q;
	logic [IDX_W-1:0]   hit_index_q;
	logic [LEVEL_W-1:0] red_level_q, green_level_q, blue_level_q;
	logic [CHAR_W-1:0]  glyph_q;
	logic               advance;
	logic               last_query;

	op_t                        op   [0:ENTRIES];
	logic [3:0][COORD_BITS-1:0] crd  [0:ENTRIES];
	res_t                       res  [0:ENTRIES];

	assign cfg_ready = 1'b1;
	assign advance   = !(rsp_valid_q && rsp_stall);
	assign req_stall = !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			count_q <= entry_count;
		end
	end

	always_comb begin
		op[0].vld   = req_valid;
		op[0].cmd   = cmd_t'(command);
		op[0].idx   = entry_index;
		op[0].red   = red;
		op[0].green = green;
		op[0].blue  = blue;
		op[0].label = label_char;
		if (command == CMD_QUERY) begin
			crd[0][0] = COORD_BITS'(point_x);
			crd[0][1] = COORD_BITS'(point_y);
			crd[0][2] = '0;
			crd[0][3] = '0;
		end else begin
			crd[0][0] = COORD_BITS'(left);
			crd[0][1] = COORD_BITS'(bottom);
			crd[0][2] = COORD_BITS'(right);
			crd[0][3] = COORD_BITS'(top);
		end
		res[0].hit       = 1'b0;
		res[0].hit_index = '0;
		res[0].red       = '0;
		res[0].green     = '0;
		res[0].blue      = '0;
		res[0].glyph     = SPACE_CHAR;
	end

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		trht_cell #(
			.INDEX      (i),
			.COORD_BITS (COORD_BITS)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.advance (advance),
			.count   (count_q),
			.in_op   (op[i]),
			.in_crd  (crd[i]),
			.in_res  (res[i]),
			.out_op  (op[i+1]),
			.out_crd (crd[i+1]),
			.out_res (res[i+1])
		);
	end

	assign last_query = op[ENTRIES].vld && (op[ENTRIES].cmd == CMD_QUERY);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= last_query;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_query) begin
			hit_q         <= res[ENTRIES].hit;
			hit_index_q   <= res[ENTRIES].hit_index;
			red_level_q   <= scale_pct(res[ENTRIES].red);
			green_level_q <= scale_pct(res[ENTRIES].green);
			blue_level_q  <= scale_pct(res[ENTRIES].blue);
			glyph_q       <= res[ENTRIES].glyph;
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign hit         = hit_q;
	assign hit_index   = hit_index_q;
	assign red_level   = red_level_q;
	assign green_level = green_level_q;
	assign blue_level  = blue_level_q;
	assign glyph       = glyph_q;

`ifndef SYNTH
	a_miss_defaults: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !hit |-> red_level == '0 && green_level == '0 &&
		blue_level == '0 && hit_index == '0 && glyph == SPACE_CHAR)
		else $error("miss result carries non-default fields");

	a_rsp_from_query: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(last_query))
		else $error("result raised without a query leaving the row");

	a_index_needs_hit: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && hit_index != '0 |-> hit)
		else $error("nonzero hit_index without hit");
`endif

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the topmost rectangle hit test: loads, point queries, count changes.
`default_nettype none
module testbench;
	import trht_pkg::*;

	localparam int ENTRIES     = 16;
	localparam int LATENCY     = ENTRIES + 1;
	localparam int CYCLE_LIMIT = 300000;

	typedef struct packed {
		logic [PT_W-1:0]   left;
		logic [PT_W-1:0]   bottom;
		logic [PT_W-1:0]   right;
		logic [PT_W-1:0]   top;
		logic [PCT_W-1:0]  red;
		logic [PCT_W-1:0]  green;
		logic [PCT_W-1:0]  blue;
		logic [CHAR_W-1:0] label;
	} rect_entry_t;

	typedef struct packed {
		cmd_t              command;
		logic [IDX_W-1:0]  slot;
		rect_entry_t       rect;
		logic [PT_W-1:0]   px;
		logic [PT_W-1:0]   py;
	} req_item_t;

	typedef struct packed {
		logic               hit;
		logic [IDX_W-1:0]   hit_index;
		logic [LEVEL_W-1:0] red_level;
		logic [LEVEL_W-1:0] green_level;
		logic [LEVEL_W-1:0] blue_level;
		logic [CHAR_W-1:0]  glyph;
	} hit_result_t;

	class hit_scoreboard;
		rect_entry_t        rects[ENTRIES];
		logic [COUNT_W-1:0] count_reg;
		hit_result_t        pending_hits[$];
		int                 errors;
		int                 loads;
		int                 queries;
		int                 hits;
		int                 settings;

		function new();
			count_reg = '0;
		endfunction

		function void set_count(logic [COUNT_W-1:0] v);
			count_reg = v;
			settings++;
		endfunction

		function logic [LEVEL_W-1:0] level_of(logic [PCT_W-1:0] pct);
			int unsigned v;
			v = (int'(pct) * 256) / 100;
			return v[LEVEL_W-1:0];
		endfunction

		function hit_result_t topmost_hit(logic [PT_W-1:0] x, logic [PT_W-1:0] y);
			hit_result_t r;
			int          n;
			r.hit         = 1'b0;
			r.hit_index   = '0;
			r.red_level   = '0;
			r.green_level = '0;
			r.blue_level  = '0;
			r.glyph       = SPACE_CHAR;
			n = (count_reg > ENTRIES) ? ENTRIES : int'(count_reg);
			for (int i = n - 1; i >= 0; i--) begin
				if (x >= rects[i].left && x <= rects[i].right &&
				    y >= rects[i].bottom && y <= rects[i].top) begin
					r.hit         = 1'b1;
					r.hit_index   = IDX_W'(i);
					r.red_level   = level_of(rects[i].red);
					r.green_level = level_of(rects[i].green);
					r.blue_level  = level_of(rects[i].blue);
					r.glyph       = rects[i].label;
					return r;
				end
			end
			return r;
		endfunction

		function void note_request(req_item_t it);
			if (it.command == CMD_LOAD) begin
				rects[it.slot] = it.rect;
				loads++;
			end else begin
				pending_hits.push_back(topmost_hit(it.px, it.py));
				queries++;
			end
		endfunction

		function void check_response(hit_result_t got);
			hit_result_t want;
			if (pending_hits.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result: hit=%0d idx=%0d glyph=%0d",
						got.hit, got.hit_index, got.glyph);
				return;
			end
			want = pending_hits.pop_front();
			if (want.hit)
				hits++;
			if (got.hit !== want.hit || got.hit_index !== want.hit_index ||
			    got.red_level !== want.red_level || got.green_level !== want.green_level ||
			    got.blue_level !== want.blue_level || got.glyph !== want.glyph) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: want hit=%0d idx=%0d rgb=%0d/%0d/%0d glyph=%0d, got hit=%0d idx=%0d rgb=%0d/%0d/%0d glyph=%0d",
						want.hit, want.hit_index, want.red_level, want.green_level,
						want.blue_level, want.glyph, got.hit, got.hit_index,
						got.red_level, got.green_level, got.blue_level, got.glyph);
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [COUNT_W-1:0] entry_count = '0;
	logic               req_valid = 1'b0;
	logic               req_stall;
	logic               command = 1'b0;
	logic [IDX_W-1:0]   entry_index = '0;
	logic [PT_W-1:0]    left = '0;
	logic [PT_W-1:0]    bottom = '0;
	logic [PT_W-1:0]    right = '0;
	logic [PT_W-1:0]    top = '0;
	logic [PCT_W-1:0]   red = '0;
	logic [PCT_W-1:0]   green = '0;
	logic [PCT_W-1:0]   blue = '0;
	logic [CHAR_W-1:0]  label_char = '0;
	logic [PT_W-1:0]    point_x = '0;
	logic [PT_W-1:0]    point_y = '0;
	logic               rsp_valid;
	logic               rsp_stall = 1'b0;
	logic               hit;
	logic [IDX_W-1:0]   hit_index;
	logic [LEVEL_W-1:0] red_level;
	logic [LEVEL_W-1:0] green_level;
	logic [LEVEL_W-1:0] blue_level;
	logic [CHAR_W-1:0]  glyph;

	hit_scoreboard book;
	hit_result_t   seen_rsp;
	int            cycle_count = 0;
	int            hold_cycles = 0;
	int            scan_x = 0;
	int            scan_y = 0;

	topmost_rectangle_hit_test #(.ENTRIES(ENTRIES), .COORD_BITS(8)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .entry_count(entry_count),
		.req_valid(req_valid), .req_stall(req_stall),
		.command(command), .entry_index(entry_index),
		.left(left), .bottom(bottom), .right(right), .top(top),
		.red(red), .green(green), .blue(blue), .label_char(label_char),
		.point_x(point_x), .point_y(point_y),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
		.hit(hit), .hit_index(hit_index),
		.red_level(red_level), .green_level(green_level), .blue_level(blue_level),
		.glyph(glyph)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			seen_rsp.hit         = hit;
			seen_rsp.hit_index   = hit_index;
			seen_rsp.red_level   = red_level;
			seen_rsp.green_level = green_level;
			seen_rsp.blue_level  = blue_level;
			seen_rsp.glyph       = glyph;
			book.check_response(seen_rsp);
		end
	end

	// receiver back-pressure: stall modes picked at random; long holds on request
	initial begin
		int stall_mode;
		int mode_left;
		int tick;
		stall_mode = 0;
		mode_left  = 0;
		tick       = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				rsp_stall <= 1'b1;
				repeat (hold_cycles) @(negedge clk);
				hold_cycles = 0;
			end else begin
				if (mode_left == 0) begin
					stall_mode = $urandom_range(0, 3);
					mode_left  = $urandom_range(20, 200);
				end
				mode_left--;
				tick++;
				case (stall_mode)
					0: rsp_stall <= 1'b0;
					1: rsp_stall <= ($urandom_range(0, 99) < 30);
					2: rsp_stall <= (tick % 4 == 3);
					default: rsp_stall <= ($urandom_range(0, 99) < 75);
				endcase
			end
		end
	end

	function automatic req_item_t mk_load(int slot, int l, int b, int r, int t,
	                                      int rp, int gp, int bp, int ch);
		req_item_t it;
		it.command     = CMD_LOAD;
		it.slot        = IDX_W'(slot);
		it.rect.left   = PT_W'(l);
		it.rect.bottom = PT_W'(b);
		it.rect.right  = PT_W'(r);
		it.rect.top    = PT_W'(t);
		it.rect.red    = PCT_W'(rp);
		it.rect.green  = PCT_W'(gp);
		it.rect.blue   = PCT_W'(bp);
		it.rect.label  = CHAR_W'(ch);
		it.px          = PT_W'($urandom);
		it.py          = PT_W'($urandom);
		return it;
	endfunction

	function automatic req_item_t mk_query(int x, int y);
		req_item_t it;
		it         = req_item_t'({$urandom, $urandom, $urandom});
		it.command = CMD_QUERY;
		it.px      = PT_W'(x);
		it.py      = PT_W'(y);
		return it;
	endfunction

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_item(input req_item_t it);
		req_valid   <= 1'b1;
		command     <= it.command;
		entry_index <= it.slot;
		left        <= it.rect.left;
		bottom      <= it.rect.bottom;
		right       <= it.rect.right;
		top         <= it.rect.top;
		red         <= it.rect.red;
		green       <= it.rect.green;
		blue        <= it.rect.blue;
		label_char  <= it.rect.label;
		point_x     <= it.px;
		point_y     <= it.py;
		do @(posedge clk); while (req_stall);
		book.note_request(it);
		@(negedge clk);
	endtask

	// idle until all results are back, then let trailing loads leave the pipe
	task automatic drain();
		req_valid <= 1'b0;
		while (book.pending_hits.size() != 0)
			@(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	task automatic write_count(input int v);
		cfg_valid   <= 1'b1;
		entry_count <= COUNT_W'(v);
		do @(posedge clk); while (!cfg_ready);
		book.set_count(COUNT_W'(v));
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_phase(input int n_items, input int no_gap_items);
		req_item_t   it;
		rect_entry_t pick;
		int          a, b, c, d, sel, burst_left, gap;
		burst_left = $urandom_range(1, 40);
		for (int n = 0; n < n_items; n++) begin
			it = req_item_t'({$urandom, $urandom, $urandom});
			it.command = ($urandom_range(0, 99) < 20) ? CMD_LOAD : CMD_QUERY;
			if (it.command == CMD_LOAD) begin
				sel = $urandom_range(0, 9);
				a = $urandom_range(0, 255);
				b = $urandom_range(0, 255);
				c = $urandom_range(0, 255);
				d = $urandom_range(0, 255);
				if (sel <= 5) begin
					it.rect.left   = PT_W'((a < b) ? a : b);
					it.rect.right  = PT_W'((a < b) ? b : a);
					it.rect.bottom = PT_W'((c < d) ? c : d);
					it.rect.top    = PT_W'((c < d) ? d : c);
				end else if (sel == 6) begin
					it.rect.left   = PT_W'($urandom_range(0, 40));
					it.rect.bottom = PT_W'($urandom_range(0, 40));
					it.rect.right  = PT_W'($urandom_range(200, 255));
					it.rect.top    = PT_W'($urandom_range(200, 255));
				end else if (sel == 7) begin
					a = $urandom_range(1, 255);
					it.rect.left  = PT_W'(a);
					it.rect.right = PT_W'($urandom_range(0, a - 1));
				end else if (sel == 8) begin
					it.rect.left   = PT_W'(a);
					it.rect.right  = PT_W'(a);
					it.rect.bottom = PT_W'(c);
					it.rect.top    = PT_W'(c);
				end else begin
					it.rect.left   = '0;
					it.rect.bottom = '0;
					it.rect.right  = '1;
					it.rect.top    = '1;
				end
				it.rect.red   = PCT_W'(($urandom_range(0, 4) == 0) ?
					$urandom_range(0, 127) : $urandom_range(0, 100));
				it.rect.green = PCT_W'(($urandom_range(0, 4) == 0) ?
					$urandom_range(0, 127) : $urandom_range(0, 100));
				it.rect.blue  = PCT_W'(($urandom_range(0, 4) == 0) ?
					$urandom_range(0, 127) : $urandom_range(0, 100));
			end else begin
				sel = $urandom_range(0, 99);
				if (sel < 40) begin
					it.px = PT_W'($urandom);
					it.py = PT_W'($urandom);
				end else if (sel < 80) begin
					pick  = book.rects[$urandom_range(0, ENTRIES - 1)];
					it.px = PT_W'($urandom_range(pick.left, pick.right));
					it.py = PT_W'($urandom_range(pick.bottom, pick.top));
				end else begin
					// raster-style scan
					it.px  = PT_W'(scan_x);
					it.py  = PT_W'(scan_y);
					scan_x = (scan_x + 3) % 256;
					if (scan_x < 3)
						scan_y = (scan_y + 5) % 256;
				end
			end
			send_item(it);
			if (n >= no_gap_items) begin
				burst_left--;
				if (burst_left <= 0) begin
					gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					if (gap > 0) begin
						req_valid <= 1'b0;
						repeat (gap) @(negedge clk);
					end
					burst_left = $urandom_range(1, 40);
				end
			end
		end
	endtask

	initial begin
		int counts[9];
		counts = '{16, 31, 0, 1, 8, 17, 16, 3, 12};
		book = new();
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// count is zero after reset: every query misses
		send_item(mk_query(0, 0));
		send_item(mk_load(0, 0, 0, 255, 255, 0, 0, 0, 0));
		send_item(mk_load(1, 10, 10, 50, 50, 100, 100, 100, 65));
		send_item(mk_load(2, 255, 255, 255, 255, 127, 127, 127, 255));
		send_item(mk_load(3, 200, 0, 100, 255, 40, 60, 80, 66));
		send_item(mk_load(4, 0, 200, 255, 100, 90, 10, 30, 67));
		send_item(mk_load(5, 0, 0, 0, 0, 1, 50, 99, 68));
		for (int i = 6; i < ENTRIES; i++)
			send_item(mk_load(i, 8 * i, 8 * i, 255 - 8 * i, 255 - 8 * i,
				7 * i, 100 - 5 * i, 3 * i, 97 + i));
		drain();
		write_count(ENTRIES);
		send_item(mk_query(0, 0));
		send_item(mk_query(255, 255));
		send_item(mk_query(128, 128));
		send_item(mk_query(150, 50));
		send_item(mk_query(230, 20));
		send_item(mk_query(30, 30));
		send_item(mk_query(255, 0));
		send_item(mk_query(20, 250));
		drain();

		for (int p = 0; p < 10; p++) begin
			write_count((p < 9) ? counts[p] : $urandom_range(0, 31));
			if (p == 1) begin
				// long receiver hold while the sender keeps pushing
				hold_cycles = 80;
				run_phase(120, 60);
			end else begin
				run_phase(115, 0);
			end
			drain();
		end

		$display("Ran %0d loads and %0d queries (%0d hits) over %0d entry_count settings",
			book.loads, book.queries, book.hits, book.settings);
		$display("%0d mismatching results, %0d results outstanding",
			book.errors, book.pending_hits.size());
		if (book.errors == 0 && book.pending_hits.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
`default_nettype wire
